[src/icppf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icppf_pkg: shared types and constants
// Codes, transaction layout and configuration bundle of the ingress policy filter.
// ----------------------------------------------------------------------------
package icppf_pkg;

    localparam int DEF_NETWORK_ENTRIES = 64;
    localparam int DEF_POLICY_ENTRIES  = 256;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_NET_WR = 2'd1;
    localparam logic [1:0] KIND_POL_WR = 2'd2;

    localparam logic [1:0] ACT_PASS     = 2'd0;
    localparam logic [1:0] ACT_REDIRECT = 2'd1;
    localparam logic [1:0] ACT_DROP     = 2'd2;

    localparam logic [2:0] RSN_SHORT   = 3'd0;
    localparam logic [2:0] RSN_DNS     = 3'd1;
    localparam logic [2:0] RSN_POLICY  = 3'd2;
    localparam logic [2:0] RSN_AUDIT   = 3'd3;
    localparam logic [2:0] RSN_BLOCKED = 3'd4;

    localparam logic [2:0] CFG_OWN_ADDRESS     = 3'd0;
    localparam logic [2:0] CFG_DNS_PORT        = 3'd1;
    localparam logic [2:0] CFG_MONITOR_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_AUDIT_MODE      = 3'd3;
    localparam logic [2:0] CFG_REDIRECT_DEVICE = 3'd4;

    typedef enum logic [2:0] {
        CLS_NET_WR,
        CLS_POL_WR,
        CLS_SHORT,
        CLS_DNS,
        CLS_SCAN
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_NET_RD,
        ST_NET_CHK,
        ST_POL_RD,
        ST_POL_CHK,
        ST_FINISH,
        ST_CLEAR
    } back_state_t;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [7:0]  table_index;
        logic [5:0]  entry_network;
        logic [31:0] entry_addr;
        logic [31:0] entry_mask;
        logic        entry_valid;
    } item_t;

    typedef struct packed {
        logic [31:0] own_address;
        logic [15:0] dns_port;
        logic        monitor_enable;
        logic        audit_mode;
        logic [31:0] redirect_device;
    } cfg_t;

endpackage
`default_nettype wire

[src/icppf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icppf_front: transaction intake and classification
// Sorts each accepted transaction of a known kind into a table write, a bypass or a scan job.
// ----------------------------------------------------------------------------
module icppf_front (
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          kind,
    input  wire logic                header_complete,
    input  wire logic [31:0]         src_addr,
    input  wire logic [31:0]         dst_addr,
    input  wire logic [15:0]         dst_port,
    input  wire logic [7:0]          table_index,
    input  wire logic [5:0]          entry_network,
    input  wire logic [31:0]         entry_addr,
    input  wire logic [31:0]         entry_mask,
    input  wire logic                entry_valid,
    input  wire icppf_pkg::cfg_t     cfg,
    input  wire logic                q_full,
    output logic                     q_push,
    output icppf_pkg::item_t         q_item
);

    logic known_kind;

    assign busy = q_full;

    always_comb
    begin
        known_kind           = 1'b1;
        q_item.cls           = icppf_pkg::CLS_SCAN;
        q_item.src_addr      = src_addr;
        q_item.dst_addr      = dst_addr;
        q_item.dst_port      = dst_port;
        q_item.table_index   = table_index;
        q_item.entry_network = entry_network;
        q_item.entry_addr    = entry_addr;
        q_item.entry_mask    = entry_mask;
        q_item.entry_valid   = entry_valid;
        case (kind)
            icppf_pkg::KIND_NET_WR: q_item.cls = icppf_pkg::CLS_NET_WR;
            icppf_pkg::KIND_POL_WR: q_item.cls = icppf_pkg::CLS_POL_WR;
            icppf_pkg::KIND_HEADER:
            begin
                if (!header_complete)
                    q_item.cls = icppf_pkg::CLS_SHORT;
                else if (dst_addr == cfg.own_address && dst_port == cfg.dns_port)
                    q_item.cls = icppf_pkg::CLS_DNS;
                else
                    q_item.cls = icppf_pkg::CLS_SCAN;
            end
            default: known_kind = 1'b0;
        endcase
    end

    // Unknown kinds are accepted and discarded here.
    assign q_push = start && !q_full && known_kind;

endmodule
`default_nettype wire

[src/icppf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icppf_queue: two-entry job queue
// Decouples intake from the table scanner.
// ----------------------------------------------------------------------------
module icppf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire icppf_pkg::item_t    push_item,
    input  wire logic                pop,
    output icppf_pkg::item_t         head,
    output logic                     empty,
    output logic                     full
);

    icppf_pkg::item_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

[src/icppf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icppf_back: table store and first-match scanner
// Executes table writes, passes short and DNS headers, and classifies other headers against both tables.
// ----------------------------------------------------------------------------
module icppf_back #(
    parameter int NETWORK_ENTRIES = icppf_pkg::DEF_NETWORK_ENTRIES,
    parameter int POLICY_ENTRIES  = icppf_pkg::DEF_POLICY_ENTRIES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire icppf_pkg::cfg_t     cfg,
    input  wire icppf_pkg::item_t    head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     done,
    output logic [1:0]               action,
    output logic [2:0]               reason,
    output logic                     audit_emit,
    output logic [5:0]               matched_network,
    output logic [31:0]              target_device,
    output logic [31:0]              allowed_count,
    output logic [31:0]              redirect_count,
    output logic [31:0]              blocked_count
);

    localparam int NAW = (NETWORK_ENTRIES > 1) ? $clog2(NETWORK_ENTRIES) : 1;
    localparam int PAW = (POLICY_ENTRIES > 1) ? $clog2(POLICY_ENTRIES) : 1;
    localparam int CLR_DEPTH = (NETWORK_ENTRIES > POLICY_ENTRIES) ?
                               NETWORK_ENTRIES : POLICY_ENTRIES;
    localparam int CLW = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    icppf_pkg::back_state_t state_reg, state_next;
    icppf_pkg::item_t       cur_reg, cur_next;
    logic [NAW:0]           net_i_reg, net_i_next;
    logic [PAW:0]           pol_k_reg, pol_k_next;
    logic [CLW:0]           clr_reg, clr_next;
    logic [5:0]             match_reg, match_next;
    logic                   hit_reg, hit_next;
    logic [31:0]            allowed_reg, allowed_next;
    logic [31:0]            redirect_reg, redirect_next;
    logic [31:0]            blocked_reg, blocked_next;
    logic                   done_reg, done_next;
    logic [1:0]             action_reg, action_next;
    logic [2:0]             reason_reg, reason_next;
    logic                   emit_reg, emit_next;
    logic [5:0]             mout_reg, mout_next;
    logic [31:0]            target_reg, target_next;

    // Each word carries its valid flag in the top bit.
    logic [64:0]            net_mem [NETWORK_ENTRIES];
    logic [54:0]            pol_mem [POLICY_ENTRIES];
    logic [64:0]            net_rd_reg;
    logic [54:0]            pol_rd_reg;

    logic                   net_we, pol_we;
    logic                   clearing;
    logic [NAW+7:0]         net_wr_wide;
    logic [PAW+7:0]         pol_wr_wide;
    logic [NAW-1:0]         net_wr_addr, net_rd_addr;
    logic [PAW-1:0]         pol_wr_addr, pol_rd_addr;
    logic [64:0]            net_wr_data;
    logic [54:0]            pol_wr_data;
    logic                   net_rd_vld, pol_rd_vld;
    logic [31:0]            ent_addr, ent_mask;
    logic [NAW:0]           net_i_inc;
    logic [PAW:0]           pol_k_inc;
    logic [CLW:0]           clr_inc;

    assign clearing    = (state_reg == icppf_pkg::ST_CLEAR);
    assign net_wr_wide = (NAW + 8)'(cur_reg.table_index);
    assign pol_wr_wide = (PAW + 8)'(cur_reg.table_index);
    assign net_wr_addr = clearing ? clr_reg[NAW-1:0] : net_wr_wide[NAW-1:0];
    assign pol_wr_addr = clearing ? clr_reg[PAW-1:0] : pol_wr_wide[PAW-1:0];
    assign net_wr_data = clearing ? 65'd0 :
                         {cur_reg.entry_valid, cur_reg.entry_addr, cur_reg.entry_mask};
    assign pol_wr_data = clearing ? 55'd0 :
                         {cur_reg.entry_valid, cur_reg.entry_network, cur_reg.dst_addr,
                          cur_reg.dst_port};
    assign net_rd_addr = net_i_reg[NAW-1:0];
    assign pol_rd_addr = pol_k_reg[PAW-1:0];
    assign net_rd_vld  = net_rd_reg[64];
    assign pol_rd_vld  = pol_rd_reg[54];
    assign ent_addr    = net_rd_reg[63:32];
    assign ent_mask    = net_rd_reg[31:0];
    assign net_i_inc   = net_i_reg + 1'b1;
    assign pol_k_inc   = pol_k_reg + 1'b1;
    assign clr_inc     = clr_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        net_i_next    = net_i_reg;
        pol_k_next    = pol_k_reg;
        clr_next      = clr_reg;
        match_next    = match_reg;
        hit_next      = hit_reg;
        allowed_next  = allowed_reg;
        redirect_next = redirect_reg;
        blocked_next  = blocked_reg;
        done_next     = 1'b0;
        action_next   = action_reg;
        reason_next   = reason_reg;
        emit_next     = emit_reg;
        mout_next     = mout_reg;
        target_next   = target_reg;
        pop           = 1'b0;
        net_we        = 1'b0;
        pol_we        = 1'b0;
        case (state_reg)
            icppf_pkg::ST_CLEAR:
            begin
                // One entry of each table is invalidated per cycle after reset.
                net_we   = 32'(clr_reg) < 32'(NETWORK_ENTRIES);
                pol_we   = 32'(clr_reg) < 32'(POLICY_ENTRIES);
                clr_next = clr_inc;
                if (clr_reg == (CLW + 1)'(CLR_DEPTH - 1))
                    state_next = icppf_pkg::ST_IDLE;
            end
            icppf_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    state_next = icppf_pkg::ST_DISPATCH;
                end
            end
            icppf_pkg::ST_DISPATCH:
            begin
                net_i_next = '0;
                pol_k_next = '0;
                match_next = 6'd0;
                hit_next   = 1'b0;
                state_next = icppf_pkg::ST_IDLE;
                case (cur_reg.cls)
                    icppf_pkg::CLS_NET_WR:
                        net_we = 32'(cur_reg.table_index) < 32'(NETWORK_ENTRIES);
                    icppf_pkg::CLS_POL_WR:
                        pol_we = 32'(cur_reg.table_index) < 32'(POLICY_ENTRIES);
                    icppf_pkg::CLS_SHORT, icppf_pkg::CLS_DNS:
                    begin
                        allowed_next = allowed_reg + 32'd1;
                        done_next    = 1'b1;
                        action_next  = icppf_pkg::ACT_PASS;
                        reason_next  = (cur_reg.cls == icppf_pkg::CLS_SHORT) ?
                                       icppf_pkg::RSN_SHORT : icppf_pkg::RSN_DNS;
                        emit_next    = 1'b0;
                        mout_next    = 6'd0;
                        target_next  = 32'd0;
                    end
                    default: state_next = icppf_pkg::ST_NET_RD;
                endcase
            end
            icppf_pkg::ST_NET_RD: state_next = icppf_pkg::ST_NET_CHK;
            icppf_pkg::ST_NET_CHK:
            begin
                if (!net_rd_vld)
                    state_next = icppf_pkg::ST_FINISH;
                else if ((ent_addr & ent_mask) == (cur_reg.src_addr & ent_mask))
                begin
                    match_next = 6'(net_i_reg);
                    state_next = icppf_pkg::ST_POL_RD;
                end
                else
                begin
                    net_i_next = net_i_inc;
                    state_next = (net_i_inc == (NAW + 1)'(NETWORK_ENTRIES)) ?
                                 icppf_pkg::ST_FINISH : icppf_pkg::ST_NET_RD;
                end
            end
            icppf_pkg::ST_POL_RD: state_next = icppf_pkg::ST_POL_CHK;
            icppf_pkg::ST_POL_CHK:
            begin
                if (pol_rd_vld && 32'(pol_rd_reg[53:48]) == 32'(net_i_reg)
                    && pol_rd_reg[47:16] == cur_reg.dst_addr
                    && pol_rd_reg[15:0] == cur_reg.dst_port)
                begin
                    hit_next   = 1'b1;
                    state_next = icppf_pkg::ST_FINISH;
                end
                else
                begin
                    pol_k_next = pol_k_inc;
                    state_next = (pol_k_inc == (PAW + 1)'(POLICY_ENTRIES)) ?
                                 icppf_pkg::ST_FINISH : icppf_pkg::ST_POL_RD;
                end
            end
            icppf_pkg::ST_FINISH:
            begin
                done_next  = 1'b1;
                emit_next  = cfg.monitor_enable;
                mout_next  = match_reg;
                state_next = icppf_pkg::ST_IDLE;
                if (hit_reg)
                begin
                    redirect_next = redirect_reg + 32'd1;
                    action_next   = icppf_pkg::ACT_REDIRECT;
                    reason_next   = icppf_pkg::RSN_POLICY;
                    target_next   = cfg.redirect_device;
                end
                else if (cfg.audit_mode)
                begin
                    blocked_next  = blocked_reg + 32'd1;
                    redirect_next = redirect_reg + 32'd1;
                    action_next   = icppf_pkg::ACT_REDIRECT;
                    reason_next   = icppf_pkg::RSN_AUDIT;
                    target_next   = cfg.redirect_device;
                end
                else
                begin
                    blocked_next = blocked_reg + 32'd1;
                    action_next  = icppf_pkg::ACT_DROP;
                    reason_next  = icppf_pkg::RSN_BLOCKED;
                    target_next  = 32'd0;
                end
            end
            default: state_next = icppf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= icppf_pkg::ST_CLEAR;
            clr_reg      <= '0;
            allowed_reg  <= 32'd0;
            redirect_reg <= 32'd0;
            blocked_reg  <= 32'd0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            allowed_reg  <= allowed_next;
            redirect_reg <= redirect_next;
            blocked_reg  <= blocked_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        net_i_reg  <= net_i_next;
        pol_k_reg  <= pol_k_next;
        match_reg  <= match_next;
        hit_reg    <= hit_next;
        action_reg <= action_next;
        reason_reg <= reason_next;
        emit_reg   <= emit_next;
        mout_reg   <= mout_next;
        target_reg <= target_next;
    end

    always_ff @(posedge clk)
    begin
        if (net_we)
            net_mem[net_wr_addr] <= net_wr_data;
        net_rd_reg <= net_mem[net_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pol_we)
            pol_mem[pol_wr_addr] <= pol_wr_data;
        pol_rd_reg <= pol_mem[pol_rd_addr];
    end

    assign done            = done_reg;
    assign action          = action_reg;
    assign reason          = reason_reg;
    assign audit_emit      = emit_reg;
    assign matched_network = mout_reg;
    assign target_device   = target_reg;
    assign allowed_count   = allowed_reg;
    assign redirect_count  = redirect_reg;
    assign blocked_count   = blocked_reg;

endmodule
`default_nettype wire

[src/ingress_cidr_port_policy_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ingress_cidr_port_policy_filter: first-match source-network policy classifier
// Classifies packet headers against a network table and a policy table.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge where start is high and busy is
// low. It is either a packet header or a write into the network or policy
// table; writes and headers are executed strictly in arrival order. Each
// header produces exactly one result, shown for a single cycle with done
// high. The receiver cannot stall the block, so results must be captured on
// the cycle they appear. A short header or a DNS header is passed, and a
// table write is executed, in the dispatch state without a table walk. A
// header that reaches classification walks the network table entry by
// entry, each step one synchronous memory read (NET_RD) plus one compare
// (NET_CHK), and, on a matching network, the policy table in the same way
// (POL_RD, POL_CHK). A two-entry queue between intake and scanner lets a
// couple of transactions be accepted while a scan runs; busy is high while
// that queue is full. After reset the scanner clears both tables, one entry
// of each per cycle, up to the larger of NETWORK_ENTRIES and POLICY_ENTRIES
// (256 entries with default sizes); transactions accepted meanwhile wait in
// the queue.
// Configuration writes are taken at any time (cfg_ready is always high) but
// should only be issued while the block is idle; unknown indexes are ignored.
module ingress_cidr_port_policy_filter #(
    parameter int NETWORK_ENTRIES = icppf_pkg::DEF_NETWORK_ENTRIES,
    parameter int POLICY_ENTRIES  = icppf_pkg::DEF_POLICY_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic        header_complete,
    input  wire logic [31:0] src_addr,
    input  wire logic [31:0] dst_addr,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic [7:0]  protocol,
    input  wire logic [7:0]  table_index,
    input  wire logic [5:0]  entry_network,
    input  wire logic [31:0] entry_addr,
    input  wire logic [31:0] entry_mask,
    input  wire logic        entry_valid,
    output logic             done,
    output logic [1:0]       action,
    output logic [2:0]       reason,
    output logic             audit_emit,
    output logic [5:0]       matched_network,
    output logic [31:0]      target_device,
    output logic [31:0]      allowed_count,
    output logic [31:0]      redirect_count,
    output logic [31:0]      blocked_count
);

    icppf_pkg::cfg_t  cfg_reg;
    icppf_pkg::item_t push_item;
    icppf_pkg::item_t head;
    logic             q_push, q_pop, q_empty, q_full;
    logic             audit_fields_unused;

    assign cfg_ready = 1'b1;

    // Source port and protocol are not used inside this block.
    assign audit_fields_unused = ^{src_port, protocol};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                icppf_pkg::CFG_OWN_ADDRESS:     cfg_reg.own_address     <= cfg_data;
                icppf_pkg::CFG_DNS_PORT:        cfg_reg.dns_port        <= cfg_data[15:0];
                icppf_pkg::CFG_MONITOR_ENABLE:  cfg_reg.monitor_enable  <= cfg_data[0];
                icppf_pkg::CFG_AUDIT_MODE:      cfg_reg.audit_mode      <= cfg_data[0];
                icppf_pkg::CFG_REDIRECT_DEVICE: cfg_reg.redirect_device <= cfg_data;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    icppf_front u_front (
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .header_complete (header_complete),
        .src_addr        (src_addr),
        .dst_addr        (dst_addr),
        .dst_port        (dst_port),
        .table_index     (table_index),
        .entry_network   (entry_network),
        .entry_addr      (entry_addr),
        .entry_mask      (entry_mask),
        .entry_valid     (entry_valid),
        .cfg             (cfg_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    icppf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    icppf_back #(
        .NETWORK_ENTRIES (NETWORK_ENTRIES),
        .POLICY_ENTRIES  (POLICY_ENTRIES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head            (head),
        .empty           (q_empty),
        .pop             (q_pop),
        .done            (done),
        .action          (action),
        .reason          (reason),
        .audit_emit      (audit_emit),
        .matched_network (matched_network),
        .target_device   (target_device),
        .allowed_count   (allowed_count),
        .redirect_count  (redirect_count),
        .blocked_count   (blocked_count)
    );

endmodule
`default_nettype wire
